### sv/arsup_pkg.sv
// package: shared types and constants of the alert repeat suppression table
package arsup_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam logic [31:0] WINDOW_RESET = 32'd60;
    localparam int PADDR_W = 3;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic        is_ipv6;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } item_t;

    typedef struct packed {
        logic seen_before;
        logic table_full;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic        is_v6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic expire;
        logic live;
        logic match;
    } check_t;

endpackage

### sv/alert_repeat_suppress_table_top.sv
// top level: alert repeat suppression table with ageing records
//
//  channel   direction  handshake                    word
//  item      in         item_valid / item_ready      item_t (time, family, address)
//  result    out        result_valid / result_ready  result_t (seen_before, table_full)
//  apb       in/out     psel/penable/pwrite, pready  window_seconds at byte 0
//
//  each word steps through accept, one record read per cycle, drain, finish
//  the single read port of the record memory paces the scan; expiry write-back overlaps the reads
//  after reset a clearing pass over every record runs before item_ready rises
//  a waiting result stalls only the finish step; the next word is taken once it leaves
module alert_repeat_suppress_table_top #(
    parameter int ENTRIES = arsup_pkg::ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  arsup_pkg::item_t               item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output arsup_pkg::result_t             result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [arsup_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import arsup_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             hit_reg, hit_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [31:0]      window_reg;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg;
    item_t            cur_reg;
    item_t            item_norm;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    entry_t           rd_entry;
    logic [ENTRY_W-1:0] rd_bits;
    check_t           check;
    logic             finish_go;
    logic             cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_wr)
        begin
            window_reg <= pwdata;
        end
    end

    // ipv4 upper bits are stored and compared as zero
    always_comb
    begin
        item_norm = item;
        if (!item.is_ipv6)
        begin
            item_norm.address_high = 64'd0;
            item_norm.address_low  = {32'd0, item.address_low[31:0]};
        end
    end

    arsup_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);

    arsup_check u_check (
        .entry  (rd_entry),
        .cur    (cur_reg),
        .window (window_reg),
        .check  (check)
    );

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign finish_go    = (state_reg == ST_FINISH) && (!result_valid_reg || result_ready);
    assign rd_en        = (state_reg == ST_SCAN);

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        chk_vld_next      = 1'b0;
        hit_next          = hit_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        result_valid_next = result_valid_reg;
        wr_en             = 1'b0;
        wr_addr           = chk_idx_reg;
        wr_data           = rd_entry;
        wr_data.valid     = 1'b0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        // checked record from the previous read
        if (chk_vld_reg)
        begin
            if (check.match)
            begin
                hit_next = 1'b1;
            end
            if (!check.live && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = chk_idx_reg;
            end
            if (check.expire)
            begin
                wr_en = 1'b1;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = '0;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                chk_vld_next = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                    if (!hit_reg && free_found_reg)
                    begin
                        wr_en             = 1'b1;
                        wr_addr           = free_idx_reg;
                        wr_data.valid     = 1'b1;
                        wr_data.is_v6     = cur_reg.is_ipv6;
                        wr_data.addr_high = cur_reg.address_high;
                        wr_data.addr_low  = cur_reg.address_low;
                        wr_data.stamp     = cur_reg.now_seconds;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            idx_reg          <= '0;
            chk_vld_reg      <= 1'b0;
            hit_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            chk_vld_reg      <= chk_vld_next;
            hit_reg          <= hit_next;
            free_found_reg   <= free_found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= idx_reg;
        free_idx_reg <= free_idx_next;
        if (item_valid && item_ready)
        begin
            cur_reg <= item_norm;
        end
        if (finish_go)
        begin
            result_reg.seen_before <= hit_reg;
            result_reg.table_full  <= !hit_reg && !free_found_reg;
        end
    end

endmodule

### sv/arsup_ram.sv
// generic single-port-write, registered-read memory
module arsup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/arsup_check.sv
// entry check: ageing and address match of one stored record
module arsup_check (
    input  arsup_pkg::entry_t entry,
    input  arsup_pkg::item_t  cur,
    input  logic [31:0]       window,
    output arsup_pkg::check_t check
);
    import arsup_pkg::*;

    logic [31:0] age;
    logic        expired;
    logic        same;

    always_comb
    begin
        age     = cur.now_seconds - entry.stamp;
        expired = (cur.now_seconds >= entry.stamp) && (age > window);
        same    = (entry.is_v6 == cur.is_ipv6)
                  && (entry.addr_high == cur.address_high)
                  && (entry.addr_low == cur.address_low);
        check.expire = entry.valid && expired;
        check.live   = entry.valid && !expired;
        check.match  = entry.valid && !expired && same;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking random and directed run of the alert repeat suppression table
module testbench;
    import arsup_pkg::*;

    localparam int ENTRIES = ENTRIES_DEFAULT;
    localparam int REG_WINDOW = 0;
    localparam int REG_SPARE = 1;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam int POOL_MAX = 128;
    localparam int PHASES = 6;
    localparam int PHASE_WORDS = 288;
    localparam int PRINT_CAP = 200;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    item_t               item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    alert_repeat_suppress_table_top #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // shadow copy of the suppression records
    bit          rec_valid [ENTRIES];
    bit          rec_v6    [ENTRIES];
    logic [63:0] rec_hi    [ENTRIES];
    logic [63:0] rec_lo    [ENTRIES];
    logic [31:0] rec_stamp [ENTRIES];
    logic [31:0] window_cfg = WINDOW_RESET;

    item_t   pending_words[$];
    result_t expected_verdicts[$];

    bit          pool_v6 [POOL_MAX];
    logic [63:0] pool_hi [POOL_MAX];
    logic [63:0] pool_lo [POOL_MAX];
    logic [31:0] cur_time = '0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  item_taken = 1'b0;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;
    int  hold_count = 0;

    int  n_errors = 0;
    int  n_words = 0;
    int  n_results = 0;
    int  n_repeats = 0;
    int  n_full = 0;
    int  n_cfg_writes = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task report_mismatch(string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic result_t judge_alert(item_t w);
        logic [63:0] hi;
        logic [63:0] lo;
        bit          hit;
        int          free_slot;
        result_t     r;
        hi = w.is_ipv6 ? w.address_high : 64'd0;
        lo = w.is_ipv6 ? w.address_low : {32'd0, w.address_low[31:0]};
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (rec_valid[i] && w.now_seconds >= rec_stamp[i] &&
                (w.now_seconds - rec_stamp[i]) > window_cfg)
                rec_valid[i] = 1'b0;
        end
        hit = 1'b0;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (rec_valid[i])
            begin
                if (rec_v6[i] == w.is_ipv6 && rec_hi[i] == hi && rec_lo[i] == lo)
                    hit = 1'b1;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        r = '0;
        if (hit)
            r.seen_before = 1'b1;
        else if (free_slot >= 0)
        begin
            rec_valid[free_slot] = 1'b1;
            rec_v6[free_slot] = w.is_ipv6;
            rec_hi[free_slot] = hi;
            rec_lo[free_slot] = lo;
            rec_stamp[free_slot] = w.now_seconds;
        end
        else
            r.table_full = 1'b1;
        return r;
    endfunction

    // input side
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_taken)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item <= pending_words.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // output side, with one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (long_hold_req && !long_hold_done)
        begin
            result_ready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count >= LONG_HOLD)
                long_hold_done <= 1'b1;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        item_taken <= rst_n && item_valid && item_ready;
        if (rst_n && result_valid && result_ready)
        begin
            n_results++;
            if (expected_verdicts.size() == 0)
                report_mismatch("result word with nothing outstanding");
            else
            begin
                want = expected_verdicts.pop_front();
                if (result.seen_before !== want.seen_before)
                    report_mismatch($sformatf("result %0d seen_before %b, want %b",
                        n_results, result.seen_before, want.seen_before));
                if (result.table_full !== want.table_full)
                    report_mismatch($sformatf("result %0d table_full %b, want %b",
                        n_results, result.table_full, want.table_full));
            end
        end
        if (rst_n && item_valid && item_ready)
        begin
            want = judge_alert(item);
            n_words++;
            n_repeats += want.seen_before;
            n_full += want.table_full;
            expected_verdicts = {expected_verdicts, want};
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("no handshake for %0d cycles, giving up", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task cfg_write(int index, logic [31:0] d);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(index * 4);
        pwdata <= d;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (index == REG_WINDOW)
            window_cfg = d;
        n_cfg_writes++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task check_window_readback;
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= PADDR_W'(REG_WINDOW * 4);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== window_cfg)
            report_mismatch($sformatf("window readback %h, want %h", prdata, window_cfg));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task push_word(logic [31:0] now, bit v6, logic [63:0] hi, logic [63:0] lo);
        item_t w;
        w.now_seconds = now;
        w.is_ipv6 = v6;
        w.address_high = hi;
        w.address_low = lo;
        pending_words = {pending_words, w};
    endtask

    task wait_drained;
        do @(posedge clk);
        while (pending_words.size() != 0 || item_valid || expected_verdicts.size() != 0);
    endtask

    task automatic run_random(int count, int pool_size);
        int          r;
        int          idx;
        logic [31:0] now;
        bit          v6;
        logic [63:0] hi;
        logic [63:0] lo;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 70)
                cur_time += $urandom_range(0, 2);
            else if (r < 86)
                cur_time += $urandom_range(3, 100);
            else if (r < 93)
                cur_time += $urandom;
            else if (r >= 97)
                cur_time = $urandom;
            now = (r >= 93 && r < 97) ? cur_time - $urandom_range(1, 30) : cur_time;
            if ($urandom_range(99) < 82)
            begin
                idx = $urandom_range(0, pool_size - 1);
                v6 = pool_v6[idx];
                hi = pool_hi[idx];
                lo = pool_lo[idx];
                // junk in the ignored ipv4 bits
                if (!v6 && $urandom_range(1))
                begin
                    hi = {$urandom, $urandom};
                    lo[63:32] = $urandom;
                end
            end
            else
            begin
                v6 = $urandom_range(1);
                hi = {$urandom, $urandom};
                lo = {$urandom, $urandom};
            end
            push_word(now, v6, hi, lo);
        end
    endtask

    initial
    begin
        logic [31:0] windows [PHASES];
        int          pools   [PHASES];
        for (int i = 0; i < POOL_MAX / 2; i++)
        begin
            pool_v6[2*i] = 1'b0;
            pool_hi[2*i] = '0;
            pool_lo[2*i] = {32'd0, $urandom};
            pool_v6[2*i+1] = 1'b1;
            pool_hi[2*i+1] = (i % 4 == 0) ? 64'd0 : {$urandom, $urandom};
            pool_lo[2*i+1] = (i % 2 == 0) ? pool_lo[2*i] : {$urandom, $urandom};
        end
        windows = '{32'hFFFF_FFFF, 32'd0, 32'd3, $urandom_range(1, 200),
                    32'h8000_0000, 32'd20};
        pools = '{100, 16, 24, 40, 80, 70};

        send_idle_pct = 33;
        recv_idle_pct = 49;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        check_window_readback;

        push_word(32'd0, 1'b0, 64'd0, 64'd0);
        push_word(32'd0, 1'b0, 64'd0, 64'd0);
        push_word(32'd1, 1'b0, '1, '1);
        push_word(32'd2, 1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF);
        push_word(32'd3, 1'b1, 64'd0, 64'd0);
        push_word(32'd4, 1'b1, '1, '1);
        push_word(32'd5, 1'b1, 64'd0, 64'h0000_0000_FFFF_FFFF);
        push_word(32'd6, 1'b1, 64'h8000_0000_0000_0000, 64'd1);
        push_word(32'd60, 1'b1, '1, '1);
        push_word(32'd63, 1'b1, 64'd0, 64'd0);
        push_word(32'd64, 1'b1, '1, '1);
        push_word(32'd65, 1'b1, '1, '1);
        push_word(32'd10, 1'b1, '1, '1);
        push_word(32'd10, 1'b0, 64'd0, 64'd0);
        push_word(32'hFFFF_FFFF, 1'b0, 64'd0, 64'h0000_0000_0A00_0001);
        push_word(32'hFFFF_FFFF, 1'b0, 64'h1234, 64'hDEAD_BEEF_0A00_0001);
        push_word(32'd0, 1'b0, 64'd0, 64'h0000_0000_0A00_0001);
        push_word(32'd0, 1'b1, 64'd0, 64'h0000_0000_0A00_0001);
        push_word(32'h5555_5555, 1'b1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        push_word(32'hAAAA_AAAA, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        wait_drained;
        cur_time = 32'hAAAA_AAAA;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 49 : 0;
            recv_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 33 : 0;
            cfg_write(REG_WINDOW, windows[ph]);
            if (ph == 0)
                cfg_write(REG_SPARE, $urandom);
            check_window_readback;
            run_random(PHASE_WORDS, pools[ph]);
            if (ph == 4)
                long_hold_req = 1'b1;
            wait_drained;
        end

        repeat (ENTRIES + 8) @(posedge clk);
        if (expected_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
        $display("run: %0d alert words checked, %0d repeats, %0d table-full verdicts",
            n_words, n_repeats, n_full);
        $display("run: %0d register writes over %0d window settings, %0d mismatches",
            n_cfg_writes, PHASES + 1, n_errors);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
